// ===== sv/ccrf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the caption triplet rate queue.
// No dependencies; every other file imports this package.
package ccrf_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CALC_W      = (FILL_W > 6) ? FILL_W : 6;

    localparam int CMDQ_DEPTH  = 4;
    localparam int CQ_AW       = $clog2(CMDQ_DEPTH);
    localparam int CQ_CW       = $clog2(CMDQ_DEPTH + 1);

    localparam int OUTQ_DEPTH  = 4;
    localparam int OQ_AW       = $clog2(OUTQ_DEPTH);
    localparam int OQ_CW       = $clog2(OUTQ_DEPTH + 2);

    localparam logic [5:0] MAX_FRAME  = 6'd40;
    localparam logic [7:0] PAD_HEADER = 8'hFA;
    localparam int         HDR_VALID  = 2;

    // Input command codes
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_EMIT  = 1'b1;

    // Register indexes
    localparam logic [1:0] CFG_TRIPLETS = 2'd0;
    localparam logic [1:0] CFG_LEGACY   = 2'd1;
    localparam logic [1:0] CFG_PASS     = 2'd2;

    typedef enum logic [1:0] {
        SRC_LEGACY  = 2'd0,
        SRC_DIGITAL = 2'd1,
        SRC_PAD     = 2'd2
    } t_src;

    typedef enum logic [1:0] {
        CMD_STORE_LEG,
        CMD_STORE_DIG,
        CMD_EMIT,
        CMD_ERROR
    } t_cmd_kind;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [23:0] trip;
        logic [5:0]  count;
        logic [2:0]  lmax;
    } t_cmd;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] data_a;
        logic [7:0] data_b;
        t_src       src;
        logic       last;
        logic       err;
    } t_result;

endpackage

// ===== sv/closed_caption_rate_fifo.sv =====
`timescale 1ns / 1ps
// Caption triplet rate queue. Incoming caption triplets (header plus two data
// bytes) are sorted: types 0 and 1 into a legacy queue, valid types 2 and 3
// into a digital queue, anything else dropped; a triplet meeting a full queue
// (128 entries) is dropped too. An emit item streams exactly one frame of
// triplets_per_frame results (saturated at 40): up to legacy_per_frame from
// the legacy queue, then digital, then padding FA 00 00, with out_last on the
// final one. If room_bytes is below three bytes per frame triplet a single
// error result comes out instead. Pass-through mode and an emit before any
// caption was stored give nothing. Timing: the front end takes one item per
// cycle while its 4-entry command queue has room. The back end takes a store
// straight from idle, issues an error result once the output queue has room,
// and runs an emit as a setup step, then one triplet per cycle while the
// output queue has room. Issued results pass through the memory read register
// and then a 4-entry output queue.
// Depends on ccrf_pkg, ccrf_front, ccrf_cmdq and ccrf_back.
module closed_caption_rate_fifo (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [5:0] i_cfg_data,
    // input item channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_in_header,
    input  logic [7:0] i_in_data_a,
    input  logic [7:0] i_in_data_b,
    input  logic [7:0] i_room_bytes,
    // result item channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_header,
    output logic [7:0] o_out_data_a,
    output logic [7:0] o_out_data_b,
    output logic [1:0] o_out_source,
    output logic       o_out_last,
    output logic       o_out_error
);
    import ccrf_pkg::*;

    logic    push;
    t_cmd    push_cmd;
    logic    q_full;
    logic    q_valid;
    t_cmd    q_cmd;
    logic    q_pop;
    t_result res;

    // Intake: hold config, classify each item into a queue command
    ccrf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_in_header  (i_in_header),
        .i_in_data_a  (i_in_data_a),
        .i_in_data_b  (i_in_data_b),
        .i_room_bytes (i_room_bytes),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_cmd   (push_cmd)
    );

    // Decouple intake from frame streaming
    ccrf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // Store triplets, stream frames
    ccrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_out_header = res.header;
    assign o_out_data_a = res.data_a;
    assign o_out_data_b = res.data_b;
    assign o_out_source = 2'(res.src);
    assign o_out_last   = res.last;
    assign o_out_error  = res.err;

endmodule

// ===== sv/ccrf_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, item intake and classification.
// Depends on ccrf_pkg; feeds commands into ccrf_cmdq.
module ccrf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [5:0]        i_cfg_data,
    output logic              o_cfg_ready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cmd,
    input  logic [7:0]        i_in_header,
    input  logic [7:0]        i_in_data_a,
    input  logic [7:0]        i_in_data_b,
    input  logic [7:0]        i_room_bytes,
    input  logic              i_q_full,
    output logic              o_push,
    output ccrf_pkg::t_cmd    o_push_cmd
);
    import ccrf_pkg::*;

    logic [5:0] r_tpf;
    logic [2:0] r_lpf;
    logic       r_pass;
    logic       r_seen;
    logic       n_seen;
    logic       accept;
    logic [5:0] count;
    logic [2:0] lmax;
    logic [7:0] need;
    logic       short_room;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign accept      = i_in_valid & ~i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpf  <= 6'd20;
            r_lpf  <= 3'd2;
            r_pass <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TRIPLETS: r_tpf  <= i_cfg_data;
                CFG_LEGACY:   r_lpf  <= i_cfg_data[2:0];
                CFG_PASS:     r_pass <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Saturate frame size, clamp legacy share to it
    always_comb begin
        count      = (r_tpf > MAX_FRAME) ? MAX_FRAME : r_tpf;
        lmax       = ({3'b000, r_lpf} > count) ? count[2:0] : r_lpf;
        need       = {2'b00, count} + {1'b0, count, 1'b0};
        short_room = i_room_bytes < need;
    end

    always_comb begin
        o_push           = 1'b0;
        o_push_cmd.kind  = CMD_EMIT;
        o_push_cmd.trip  = {i_in_header, i_in_data_a, i_in_data_b};
        o_push_cmd.count = count;
        o_push_cmd.lmax  = lmax;
        n_seen           = r_seen;
        if (accept && !r_pass) begin
            if (i_cmd == OP_STORE) begin
                n_seen = 1'b1;
                if (!i_in_header[1]) begin
                    o_push          = 1'b1;
                    o_push_cmd.kind = CMD_STORE_LEG;
                end else if (i_in_header[HDR_VALID]) begin
                    o_push          = 1'b1;
                    o_push_cmd.kind = CMD_STORE_DIG;
                end
            end else if (r_seen) begin
                if (short_room) begin
                    o_push          = 1'b1;
                    o_push_cmd.kind = CMD_ERROR;
                end else if (count != 6'd0) begin
                    o_push          = 1'b1;
                    o_push_cmd.kind = CMD_EMIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else begin
            r_seen <= n_seen;
        end
    end

endmodule

// ===== sv/ccrf_cmdq.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on ccrf_pkg for the command type and depth.
module ccrf_cmdq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ccrf_pkg::t_cmd    i_cmd,
    output logic              o_full,
    output logic              o_valid,
    output ccrf_pkg::t_cmd    o_cmd,
    input  logic              i_pop
);
    import ccrf_pkg::*;

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [CQ_AW-1:0] r_wr;
    logic [CQ_AW-1:0] r_rd;
    logic [CQ_CW-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_cnt == CQ_CW'(CMDQ_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == CQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == CQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/ccrf_back.sv =====
`timescale 1ns / 1ps
// Back end: the two caption queues, the frame sequencer and the output queue.
// Depends on ccrf_pkg; takes commands from ccrf_cmdq.
module ccrf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  ccrf_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ccrf_pkg::t_result o_res
);
    import ccrf_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    // Caption queues
    logic [23:0]       r_leg_mem [QUEUE_DEPTH];
    logic [23:0]       r_dig_mem [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_leg_head, r_leg_tail, r_dig_head, r_dig_tail;
    logic [FILL_W-1:0] r_leg_fill, r_dig_fill;
    logic [23:0]       r_leg_rd, r_dig_rd;

    // Frame sequencer
    logic [5:0] r_count, r_slot, r_nl, r_nld;
    logic [CALC_W-1:0] leg_fill_x, dig_fill_x, nl_x, rem_x, nd_x;

    // Read stage and output queue
    logic             r_s1_valid, r_s1_last, r_s1_err;
    t_src             r_s1_src;
    t_result          s1_res;
    t_result          r_oq [OUTQ_DEPTH];
    logic [OQ_AW-1:0] r_oq_rd, r_oq_wr;
    logic [OQ_CW-1:0] r_oq_cnt;
    logic [OQ_CW-1:0] occ_sum;
    logic             slot_free;
    logic             oq_pop;

    // Sequencer outputs
    logic leg_wr, dig_wr, leg_rd, dig_rd, start_emit;
    logic issue, issue_last, issue_err;
    t_src issue_src;

    assign occ_sum   = r_oq_cnt + OQ_CW'(r_s1_valid);
    assign slot_free = occ_sum < OQ_CW'(OUTQ_DEPTH);

    // Frame split: legacy share first, digital next, padding for the rest
    always_comb begin
        leg_fill_x = CALC_W'(r_leg_fill);
        dig_fill_x = CALC_W'(r_dig_fill);
        nl_x       = (leg_fill_x < CALC_W'(i_cmd.lmax)) ? leg_fill_x : CALC_W'(i_cmd.lmax);
        rem_x      = CALC_W'(i_cmd.count) - nl_x;
        nd_x       = (dig_fill_x < rem_x) ? dig_fill_x : rem_x;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && i_cmd.kind == CMD_EMIT) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (slot_free && r_slot == r_count - 6'd1) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop  = 1'b0;
        leg_wr     = 1'b0;
        dig_wr     = 1'b0;
        leg_rd     = 1'b0;
        dig_rd     = 1'b0;
        start_emit = 1'b0;
        issue      = 1'b0;
        issue_last = 1'b0;
        issue_err  = 1'b0;
        issue_src  = SRC_LEGACY;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        CMD_STORE_LEG: begin
                            o_cmd_pop = 1'b1;
                            leg_wr    = r_leg_fill < FILL_W'(QUEUE_DEPTH);
                        end
                        CMD_STORE_DIG: begin
                            o_cmd_pop = 1'b1;
                            dig_wr    = r_dig_fill < FILL_W'(QUEUE_DEPTH);
                        end
                        CMD_EMIT: begin
                            o_cmd_pop  = 1'b1;
                            start_emit = 1'b1;
                        end
                        CMD_ERROR: begin
                            if (slot_free) begin
                                o_cmd_pop  = 1'b1;
                                issue      = 1'b1;
                                issue_last = 1'b1;
                                issue_err  = 1'b1;
                            end
                        end
                        default: o_cmd_pop = 1'b1;
                    endcase
                end
            end
            BK_EMIT: begin
                if (slot_free) begin
                    issue      = 1'b1;
                    issue_last = r_slot == r_count - 6'd1;
                    if (r_slot < r_nl) begin
                        issue_src = SRC_LEGACY;
                        leg_rd    = 1'b1;
                    end else if (r_slot < r_nld) begin
                        issue_src = SRC_DIGITAL;
                        dig_rd    = 1'b1;
                    end else begin
                        issue_src = SRC_PAD;
                    end
                end
            end
            default: ;
        endcase
    end

    // Queue storage: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (leg_wr) begin
            r_leg_mem[r_leg_tail] <= i_cmd.trip;
        end
        if (leg_rd) begin
            r_leg_rd <= r_leg_mem[r_leg_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dig_wr) begin
            r_dig_mem[r_dig_tail] <= i_cmd.trip;
        end
        if (dig_rd) begin
            r_dig_rd <= r_dig_mem[r_dig_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_leg_head <= '0;
            r_leg_tail <= '0;
            r_leg_fill <= '0;
            r_dig_head <= '0;
            r_dig_tail <= '0;
            r_dig_fill <= '0;
            r_s1_valid <= 1'b0;
            r_slot     <= '0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= issue;
            if (leg_wr) begin
                r_leg_tail <= (r_leg_tail == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_leg_tail + 1'b1;
                r_leg_fill <= r_leg_fill + 1'b1;
            end else if (leg_rd) begin
                r_leg_head <= (r_leg_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_leg_head + 1'b1;
                r_leg_fill <= r_leg_fill - 1'b1;
            end
            if (dig_wr) begin
                r_dig_tail <= (r_dig_tail == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_dig_tail + 1'b1;
                r_dig_fill <= r_dig_fill + 1'b1;
            end else if (dig_rd) begin
                r_dig_head <= (r_dig_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_dig_head + 1'b1;
                r_dig_fill <= r_dig_fill - 1'b1;
            end
            if (start_emit) begin
                r_slot <= '0;
            end else if (issue && r_state == BK_EMIT) begin
                r_slot <= r_slot + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_emit) begin
            r_count <= i_cmd.count;
            r_nl    <= nl_x[5:0];
            r_nld   <= nl_x[5:0] + nd_x[5:0];
        end
        if (issue) begin
            r_s1_src  <= issue_src;
            r_s1_last <= issue_last;
            r_s1_err  <= issue_err;
        end
    end

    always_comb begin
        s1_res.src  = r_s1_src;
        s1_res.last = r_s1_last;
        s1_res.err  = r_s1_err;
        if (r_s1_err) begin
            {s1_res.header, s1_res.data_a, s1_res.data_b} = 24'd0;
        end else begin
            case (r_s1_src)
                SRC_LEGACY:  {s1_res.header, s1_res.data_a, s1_res.data_b} = r_leg_rd;
                SRC_DIGITAL: {s1_res.header, s1_res.data_a, s1_res.data_b} = r_dig_rd;
                default:     {s1_res.header, s1_res.data_a, s1_res.data_b} = {PAD_HEADER, 16'd0};
            endcase
        end
    end

    // Output queue
    assign o_out_valid = r_oq_cnt != '0;
    assign o_res       = r_oq[r_oq_rd];
    assign oq_pop      = o_out_valid & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_oq[r_oq_wr] <= s1_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_rd  <= '0;
            r_oq_wr  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_oq_wr <= (r_oq_wr == OQ_AW'(OUTQ_DEPTH - 1)) ? '0 : r_oq_wr + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rd <= (r_oq_rd == OQ_AW'(OUTQ_DEPTH - 1)) ? '0 : r_oq_rd + 1'b1;
            end
            if (r_s1_valid && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + 1'b1;
            end else if (oq_pop && !r_s1_valid) begin
                r_oq_cnt <= r_oq_cnt - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_leg_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leg_fill <= FILL_W'(QUEUE_DEPTH))
        else $error("legacy fill above depth");
    a_dig_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dig_fill <= FILL_W'(QUEUE_DEPTH))
        else $error("digital fill above depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (leg_rd |-> r_leg_fill != '0) and (dig_rd |-> r_dig_fill != '0))
        else $error("read from empty caption queue");
    a_oq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> r_oq_cnt < OQ_CW'(OUTQ_DEPTH))
        else $error("output queue overflow");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_EMIT |-> r_slot < r_count)
        else $error("frame slot beyond frame size");
`endif

endmodule

// ===== tb/closed_caption_rate_fifo_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for closed_caption_rate_fifo: directed table, then random
// caption traffic checked against an in-bench queue predictor. Depends on ccrf_pkg.
module closed_caption_rate_fifo_tb;
    import ccrf_pkg::*;

    localparam int SETTLE_CYCLES = 60;   // drain of the command and output queues
    localparam int LONG_HOLD     = 400;  // receiver hold-off that backs up the block
    localparam int SCRIPT_ROWS   = 34;

    // How a directed row is checked: by the predictor, or by a typed-in outcome.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_SILENT,
        ROW_REJECT
    } t_row_chk;

    typedef struct packed {
        logic       is_cfg;
        logic [1:0] idx;
        logic [5:0] val;
        logic       cmd;
        logic [7:0] hdr;
        logic [7:0] data_a;
        logic [7:0] data_b;
        logic [7:0] room;
        t_row_chk   chk;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [5:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_cmd;
    logic [7:0] i_in_header;
    logic [7:0] i_in_data_a;
    logic [7:0] i_in_data_b;
    logic [7:0] i_room_bytes;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_header;
    logic [7:0] o_out_data_a;
    logic [7:0] o_out_data_b;
    logic [1:0] o_out_source;
    logic       o_out_last;
    logic       o_out_error;

    // Predictor state: both caption queues, the seen flag and the registers.
    logic [23:0] legacy_fifo[$];
    logic [23:0] digital_fifo[$];
    logic        seen_caption;
    logic [5:0]  frame_cfg;
    logic [2:0]  legacy_cfg;
    logic        pass_cfg;

    t_result frame_out[$];          // triplets of the item just accepted
    t_result pending_triplets[$];   // triplets still owed by the block
    int      mismatches;
    bit      quiet;                 // no idling on either side
    bit      hold_request;          // ask the receiver for one long hold-off
    t_row    script [SCRIPT_ROWS];

    closed_caption_rate_fifo DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_in_header  (i_in_header),
        .i_in_data_a  (i_in_data_a),
        .i_in_data_b  (i_in_data_b),
        .i_room_bytes (i_room_bytes),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_header (o_out_header),
        .o_out_data_a (o_out_data_a),
        .o_out_data_b (o_out_data_b),
        .o_out_source (o_out_source),
        .o_out_last   (o_out_last),
        .o_out_error  (o_out_error)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic t_result make_triplet(logic [23:0] trip, t_src src);
        t_result r;
        r.header = trip[23:16];
        r.data_a = trip[15:8];
        r.data_b = trip[7:0];
        r.src    = src;
        r.last   = 1'b0;
        r.err    = 1'b0;
        return r;
    endfunction

    // Room refusal: one all-zero triplet flagged last and error.
    function automatic t_result room_error();
        t_result r;
        r = make_triplet(24'h0, SRC_LEGACY);
        r.last = 1'b1;
        r.err  = 1'b1;
        return r;
    endfunction

    // Frame size with the 40-triplet saturation applied.
    function automatic int frame_len();
        return (frame_cfg > MAX_FRAME) ? int'(MAX_FRAME) : int'(frame_cfg);
    endfunction

    // Sort a stored triplet, or build one frame of output triplets.
    task automatic caption_queue_step(input logic cmd, input logic [7:0] hdr,
                                      input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] room);
        int      count;
        int      legacy_max;
        t_result r;
        frame_out.delete();
        if (pass_cfg)
            return;
        if (cmd == OP_STORE) begin
            seen_caption = 1'b1;
            // types 0 and 1 are legacy whatever the valid bit says
            if (hdr[1:0] < 2'd2) begin
                if (legacy_fifo.size() < QUEUE_DEPTH)
                    legacy_fifo.push_back({hdr, a, b});
            end else if (hdr[HDR_VALID]) begin
                if (digital_fifo.size() < QUEUE_DEPTH)
                    digital_fifo.push_back({hdr, a, b});
            end
            return;
        end
        if (!seen_caption)
            return;
        count      = frame_len();
        legacy_max = (int'(legacy_cfg) > count) ? count : int'(legacy_cfg);
        if (int'(room) < count * 3) begin
            frame_out.push_back(room_error());
            return;
        end
        while (frame_out.size() < legacy_max && legacy_fifo.size() > 0)
            frame_out.push_back(make_triplet(legacy_fifo.pop_front(), SRC_LEGACY));
        while (frame_out.size() < count && digital_fifo.size() > 0)
            frame_out.push_back(make_triplet(digital_fifo.pop_front(), SRC_DIGITAL));
        while (frame_out.size() < count)
            frame_out.push_back(make_triplet({PAD_HEADER, 16'h0000}, SRC_PAD));
        if (count > 0) begin
            r = frame_out.pop_back();
            r.last = 1'b1;
            frame_out.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------- drivers

    // Offer one item, hold it through stalls, then record what it owes.
    task automatic offer(input logic cmd, input logic [7:0] hdr, input logic [7:0] a,
                         input logic [7:0] b, input logic [7:0] room, input t_row_chk chk);
        if (!quiet && $urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_in_header  <= hdr;
        i_in_data_a  <= a;
        i_in_data_b  <= b;
        i_room_bytes <= room;
        do @(posedge i_clk); while (o_in_stall);
        caption_queue_step(cmd, hdr, a, b, room);
        case (chk)
            ROW_PREDICT: foreach (frame_out[i]) pending_triplets.push_back(frame_out[i]);
            ROW_REJECT:  pending_triplets.push_back(room_error());
            default: ;
        endcase
    endtask

    // Drop valid and wait until every owed triplet has come out.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_triplets.size() != 0);
    endtask

    // Write one register once the block has gone quiet.
    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TRIPLETS: frame_cfg  = val;
            CFG_LEGACY:   legacy_cfg = val[2:0];
            CFG_PASS:     pass_cfg   = val[0];
            default: ;
        endcase
    endtask

    // Random item: mostly well-formed captions and emits with enough room.
    task automatic random_item(input int emit_pct, input int legacy_pct);
        logic       cmd;
        logic [7:0] hdr;
        logic [7:0] room;
        int         need;
        cmd = ($urandom_range(99) < emit_pct) ? OP_EMIT : OP_STORE;
        hdr = 8'($urandom_range(255));
        if ($urandom_range(99) < legacy_pct) begin
            hdr[1] = 1'b0;
        end else if ($urandom_range(9) != 0) begin
            hdr[1]         = 1'b1;
            hdr[HDR_VALID] = 1'b1;
        end
        need = frame_len() * 3;
        if (need > 0 && $urandom_range(9) == 0)
            room = 8'($urandom_range(need - 1));
        else
            room = 8'($urandom_range(need, 255));
        offer(cmd, hdr, 8'($urandom_range(255)), 8'($urandom_range(255)), room, ROW_PREDICT);
    endtask

    function automatic t_row item_row(logic cmd, logic [7:0] hdr, logic [7:0] a,
                                      logic [7:0] b, logic [7:0] room, t_row_chk chk);
        return '{is_cfg: 1'b0, idx: CFG_TRIPLETS, val: 6'd0, cmd: cmd, hdr: hdr,
                 data_a: a, data_b: b, room: room, chk: chk};
    endfunction

    function automatic t_row cfg_row(logic [1:0] idx, logic [5:0] val);
        return '{is_cfg: 1'b1, idx: idx, val: val, cmd: OP_STORE, hdr: 8'h00,
                 data_a: 8'h00, data_b: 8'h00, room: 8'h00, chk: ROW_SILENT};
    endfunction

    // ---------------------------------------------------------------- receiver

    // Random stall bursts, plus one long hold-off on request.
    initial begin
        int stall_len;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(5) == 0) begin
                stall_len = $urandom_range(1, 10);
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- checker

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("[%0d ns] %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_triplets.size() == 0) begin
                $display("[%0d ns] unexpected triplet: expected none, actual %0h %0h %0h src %0d",
                         $time, o_out_header, o_out_data_a, o_out_data_b, o_out_source);
                mismatches++;
            end else begin
                want = pending_triplets.pop_front();
                check_field("out_header", want.header, o_out_header);
                check_field("out_data_a", want.data_a, o_out_data_a);
                check_field("out_data_b", want.data_b, o_out_data_b);
                check_field("out_source", 8'(want.src), 8'(o_out_source));
                check_field("out_last", 8'(want.last), 8'(o_out_last));
                check_field("out_error", 8'(want.err), 8'(o_out_error));
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        int overflow;
        int frame_pick;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_TRIPLETS;
        i_cfg_data   = 6'd0;
        i_in_valid   = 1'b0;
        i_cmd        = OP_STORE;
        i_in_header  = 8'h00;
        i_in_data_a  = 8'h00;
        i_in_data_b  = 8'h00;
        i_room_bytes = 8'h00;
        mismatches   = 0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        seen_caption = 1'b0;
        frame_cfg    = 6'd20;
        legacy_cfg   = 3'd2;
        pass_cfg     = 1'b0;

        script = '{
            item_row(OP_EMIT,  8'h00, 8'h00, 8'h00, 8'hFF, ROW_SILENT),  // nothing seen yet
            item_row(OP_STORE, 8'hFC, 8'h00, 8'hFF, 8'h00, ROW_PREDICT),
            item_row(OP_STORE, 8'h01, 8'hFF, 8'h00, 8'hFF, ROW_PREDICT),
            item_row(OP_STORE, 8'h07, 8'hAA, 8'h55, 8'h00, ROW_PREDICT),
            item_row(OP_STORE, 8'h02, 8'h12, 8'h34, 8'h00, ROW_PREDICT),  // invalid DTVCC
            item_row(OP_STORE, 8'hFE, 8'hFF, 8'hFF, 8'h00, ROW_PREDICT),
            item_row(OP_STORE, 8'hFB, 8'h5A, 8'hA5, 8'h00, ROW_PREDICT),  // invalid DTVCC
            item_row(OP_EMIT,  8'h00, 8'h00, 8'h00, 8'h00, ROW_REJECT),
            item_row(OP_EMIT,  8'h00, 8'h00, 8'h00, 8'd60, ROW_PREDICT),  // room exactly fits
            item_row(OP_EMIT,  8'hFF, 8'hFF, 8'hFF, 8'hFF, ROW_PREDICT),  // queues empty: pads
            cfg_row(CFG_TRIPLETS, 6'd63),                                 // saturates to 40
            item_row(OP_EMIT,  8'h00, 8'h00, 8'h00, 8'd119, ROW_REJECT),
            item_row(OP_EMIT,  8'h00, 8'h00, 8'h00, 8'd120, ROW_PREDICT),
            cfg_row(CFG_TRIPLETS, 6'd2),
            cfg_row(CFG_LEGACY, 6'd4),                                    // share above frame
            item_row(OP_STORE, 8'h00, 8'h11, 8'h22, 8'h00, ROW_PREDICT),
            item_row(OP_STORE, 8'h05, 8'h33, 8'h44, 8'h00, ROW_PREDICT),
            item_row(OP_STORE, 8'h80, 8'h55, 8'h66, 8'h00, ROW_PREDICT),
            item_row(OP_STORE, 8'h06, 8'h77, 8'h88, 8'h00, ROW_PREDICT),
            item_row(OP_EMIT,  8'h00, 8'h00, 8'h00, 8'd6,  ROW_PREDICT),
            cfg_row(CFG_TRIPLETS, 6'd0),
            item_row(OP_EMIT,  8'h00, 8'h00, 8'h00, 8'h00, ROW_SILENT),   // empty frame
            cfg_row(CFG_TRIPLETS, 6'd40),
            cfg_row(CFG_LEGACY, 6'd0),
            item_row(OP_EMIT,  8'h00, 8'h00, 8'h00, 8'hFF, ROW_PREDICT),
            cfg_row(CFG_PASS, 6'd1),
            item_row(OP_STORE, 8'hFC, 8'h12, 8'h34, 8'h00, ROW_SILENT),
            item_row(OP_EMIT,  8'h00, 8'h00, 8'h00, 8'h00, ROW_SILENT),
            cfg_row(CFG_PASS, 6'd0),
            cfg_row(CFG_LEGACY, 6'd7),
            cfg_row(CFG_TRIPLETS, 6'd1),
            item_row(OP_EMIT,  8'h00, 8'h00, 8'h00, 8'd3,  ROW_PREDICT),
            cfg_row(CFG_TRIPLETS, 6'd20),
            cfg_row(CFG_LEGACY, 6'd2)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[row]) begin
            if (script[row].is_cfg)
                write_reg(script[row].idx, script[row].val);
            else
                offer(script[row].cmd, script[row].hdr, script[row].data_a,
                      script[row].data_b, script[row].room, script[row].chk);
        end

        // Fill the legacy queue and push a few more into it to hit the drop path.
        overflow = 0;
        while (legacy_fifo.size() < QUEUE_DEPTH || overflow < 6) begin
            if (legacy_fifo.size() == QUEUE_DEPTH)
                overflow++;
            random_item(0, 95);
        end

        // Full frames against a receiver that holds off: the block must back up.
        write_reg(CFG_TRIPLETS, 6'd40);
        write_reg(CFG_LEGACY, 6'd4);
        hold_request = 1'b1;
        repeat (16) random_item(60, 50);

        // Random settings per phase; the last phase runs without idling.
        for (int phase = 0; phase < 5; phase++) begin
            case ($urandom_range(4))
                0:       frame_pick = 0;
                1:       frame_pick = 1;
                2:       frame_pick = 40;
                3:       frame_pick = 63;
                default: frame_pick = $urandom_range(2, 39);
            endcase
            write_reg(CFG_TRIPLETS, 6'(frame_pick));
            write_reg(CFG_LEGACY, 6'($urandom_range(4)));
            write_reg(CFG_PASS, (phase < 4 && $urandom_range(5) == 0) ? 6'd1 : 6'd0);
            if (phase == 4)
                quiet = 1'b1;
            for (int n = 0; n < 16; n++) begin
                // sender waits out every owed triplet once, mid-stream
                if (phase == 1 && n == 8)
                    wait_drain();
                random_item(35, 40);
            end
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop if the block hangs or never delivers what it owes.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
